// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the watchdog RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define MCHW_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition implies another one in the same cycle, outside reset.
`define MCHW_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mchw_pkg.sv =====
// Types and constants of the multi-channel heartbeat watchdog.
package mchw_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int NUM_CHANNELS_DEF = 8;
	localparam int CNT_W = 4;
	localparam int TIME_W = 32;
	localparam int TMO_W = 16;
	localparam int CFG_DATA_W = 64;

	localparam logic [TMO_W-1:0] PING_GAP_RESET = 16'd20;
	localparam logic [TMO_W-1:0] FALLBACK_TIMEOUT = 16'(PING_GAP_RESET * 2);
	localparam logic [CFG_DATA_W-1:0] TIMEOUT_RESET = 64'h0028_0028_0028_0028;
	localparam logic [CNT_W-1:0] DRIVER_COUNT_RESET = 4'd8;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_PONG = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		REG_DRIVER_COUNT  = 2'd0,
		REG_PING_GAP      = 2'd1,
		REG_TIMEOUTS_LOW  = 2'd2,
		REG_TIMEOUTS_HIGH = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		kind_t             kind;
		logic [TIME_W-1:0] now;
		logic [2:0]        channel;
	} item_t;

	typedef struct packed {
		logic [7:0]  ping_mask;
		logic [7:0]  restart_mask;
		logic [7:0]  waiting_mask;
		logic        pong_ignored;
		logic [15:0] restart_count;
	} result_t;

	typedef struct packed {
		cfg_reg_t              addr;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_t;

	// Per-channel control from the top level.
	typedef struct packed {
		logic step;
		logic tick;
		logic enabled;
		logic pong_hit;
	} chan_ctl_t;

	// Per-channel outcome of the word in flight.
	typedef struct packed {
		logic        ping;
		logic        restart;
		logic        waiting;
		logic [15:0] count;
	} chan_stat_t;

endpackage

// ===== rtl/core/mchw_item_if.sv =====
// Input channel carrying tick and pong words.
interface mchw_item_if;
	logic                valid;
	logic                ready;
	mchw_pkg::item_t     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mchw_result_if.sv =====
// Output channel carrying one result word per input word.
interface mchw_result_if;
	logic                valid;
	logic                ready;
	mchw_pkg::result_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mchw_cfg_if.sv =====
// Configuration write channel.
interface mchw_cfg_if;
	logic                valid;
	logic                ready;
	mchw_pkg::cfg_t      data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mchw_chan.sv =====
// State and checks of one supervised channel.
module mchw_chan (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mchw_pkg::chan_ctl_t             ctl,
	input  logic [mchw_pkg::TIME_W-1:0]     now,
	input  logic [mchw_pkg::TMO_W-1:0]      ping_gap,
	input  logic [mchw_pkg::TMO_W-1:0]      timeout,
	output mchw_pkg::chan_stat_t            stat
);

	logic [mchw_pkg::TIME_W-1:0] last_q;
	logic                        wait_q;
	logic [15:0]                 count_q;

	logic [mchw_pkg::TIME_W-1:0] age;
	logic                        ping;
	logic                        restart;
	logic                        wait_d;
	logic [15:0]                 count_d;

	// Age wraps modulo the time width. A channel pinged now has age zero, so it
	// can never time out on the same tick.
	always_comb begin
		age = now - last_q;
		ping = ctl.tick && ctl.enabled && !wait_q &&
			(age >= {{(mchw_pkg::TIME_W-mchw_pkg::TMO_W){1'b0}}, ping_gap});
		restart = ctl.tick && ctl.enabled && wait_q &&
			(age > {{(mchw_pkg::TIME_W-mchw_pkg::TMO_W){1'b0}}, timeout});
		if (ping) begin
			wait_d = 1'b1;
		end else if (restart || (ctl.pong_hit && ctl.enabled)) begin
			wait_d = 1'b0;
		end else begin
			wait_d = wait_q;
		end
		if (restart && (count_q != mchw_pkg::COUNT_MAX)) begin
			count_d = count_q + 16'd1;
		end else begin
			count_d = count_q;
		end
	end

	assign stat = '{ping: ping, restart: restart, waiting: wait_d, count: count_d};

	// Channel state moves only when the word in flight is retired.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			wait_q <= 1'b0;
			count_q <= '0;
		end else if (ctl.step) begin
			if (ping || restart) begin
				last_q <= now;
			end
			wait_q <= wait_d;
			count_q <= count_d;
		end
	end

endmodule

// ===== rtl/core/multi_channel_heartbeat_watchdog.sv =====
// An accepted word moves from the input stage register to the output register.
// Throughput: one word per cycle unless the output stalls; every channel runs its
// subtract-and-compare checks in parallel within the single processing stage, and state
// updates land before the next word.
// Reset: asynchronous, active low; clears all channel state and loads register defaults
// (eight channels, ping delay 20, timeouts 40). No clearing pass is needed.
`include "assert_macros.svh"

module multi_channel_heartbeat_watchdog #(
	parameter int NUM_CHANNELS = mchw_pkg::NUM_CHANNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mchw_item_if.sink     item,
	mchw_result_if.source result,
	mchw_cfg_if.sink      cfg
);

	localparam int MAXC = mchw_pkg::MAX_CHANNELS;
	localparam logic [mchw_pkg::CNT_W-1:0] NUM_CH_CNT = mchw_pkg::CNT_W'(NUM_CHANNELS);

	// Configuration registers.
	logic [mchw_pkg::CNT_W-1:0]      driver_count_q;
	logic [mchw_pkg::TMO_W-1:0]      ping_gap_q;
	logic [mchw_pkg::CFG_DATA_W-1:0] timeouts_low_q;
	logic [mchw_pkg::CFG_DATA_W-1:0] timeouts_high_q;

	// Input stage and result register.
	logic                       valid_s1;
	mchw_pkg::kind_t            kind_s1;
	logic [mchw_pkg::TIME_W-1:0] now_s1;
	logic [2:0]                 channel_s1;
	logic                       result_valid_q;
	mchw_pkg::result_t          result_q;

	logic                       advance;
	logic                       step;
	logic                       is_tick;
	logic [mchw_pkg::CNT_W-1:0] enabled_n;
	logic [2*mchw_pkg::CFG_DATA_W-1:0] timeouts_all;

	logic [MAXC-1:0] ping_all;
	logic [MAXC-1:0] restart_all;
	logic [MAXC-1:0] waiting_all;
	logic [15:0]     count_all [MAXC];
	mchw_pkg::result_t result_d;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			driver_count_q <= mchw_pkg::DRIVER_COUNT_RESET;
			ping_gap_q <= mchw_pkg::PING_GAP_RESET;
			timeouts_low_q <= mchw_pkg::TIMEOUT_RESET;
			timeouts_high_q <= mchw_pkg::TIMEOUT_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.addr)
				mchw_pkg::REG_DRIVER_COUNT: driver_count_q <= cfg.data.wdata[mchw_pkg::CNT_W-1:0];
				mchw_pkg::REG_PING_GAP: ping_gap_q <= cfg.data.wdata[mchw_pkg::TMO_W-1:0];
				mchw_pkg::REG_TIMEOUTS_LOW: timeouts_low_q <= cfg.data.wdata;
				mchw_pkg::REG_TIMEOUTS_HIGH: timeouts_high_q <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves whenever it is empty or the result register is free or drains.
	assign advance = !result_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign step = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1 <= item.data.kind;
			now_s1 <= item.data.now;
			channel_s1 <= item.data.channel;
		end
	end

	// Enabled count is clamped to the number of built channels.
	assign enabled_n = (driver_count_q > NUM_CH_CNT) ? NUM_CH_CNT : driver_count_q;
	assign is_tick = (kind_s1 == mchw_pkg::KIND_TICK);
	assign timeouts_all = {timeouts_high_q, timeouts_low_q};

	// One checker per built channel; absent channels read as idle with a zero count.
	for (genvar i = 0; i < MAXC; i++) begin : g_ch
		if (i < NUM_CHANNELS) begin : g_on
			mchw_pkg::chan_ctl_t        ctl;
			mchw_pkg::chan_stat_t       stat;
			logic [mchw_pkg::TMO_W-1:0] tmo_raw;
			logic [mchw_pkg::TMO_W-1:0] tmo;

			assign tmo_raw = timeouts_all[mchw_pkg::TMO_W*i +: mchw_pkg::TMO_W];
			assign tmo = (tmo_raw == '0) ? mchw_pkg::FALLBACK_TIMEOUT : tmo_raw;
			assign ctl = '{
				step: step,
				tick: is_tick,
				enabled: (mchw_pkg::CNT_W'(i) < enabled_n),
				pong_hit: !is_tick && (channel_s1 == 3'(i))
			};

			mchw_chan u_chan (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.now        (now_s1),
				.ping_gap   (ping_gap_q),
				.timeout    (tmo),
				.stat       (stat)
			);

			assign ping_all[i] = stat.ping;
			assign restart_all[i] = stat.restart;
			assign waiting_all[i] = stat.waiting;
			assign count_all[i] = stat.count;
		end else begin : g_off
			assign ping_all[i] = 1'b0;
			assign restart_all[i] = 1'b0;
			assign waiting_all[i] = 1'b0;
			assign count_all[i] = '0;
		end
	end

	// Assemble the result word.
	always_comb begin
		result_d.ping_mask = ping_all;
		result_d.restart_mask = restart_all;
		result_d.waiting_mask = waiting_all;
		result_d.pong_ignored = !is_tick && ({1'b0, channel_s1} >= enabled_n);
		result_d.restart_count = count_all[channel_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result_d;
		end
	end

	assign result.valid = result_valid_q;
	assign result.data = result_q;

	// A pong word never pings or restarts a channel.
	`MCHW_ASSERT_IMPLY(a_pong_quiet, valid_s1 && !is_tick, (ping_all == '0) && (restart_all == '0), "pong raised a ping or restart")
	// A channel is never pinged and restarted on the same tick.
	`MCHW_ASSERT_ALWAYS(a_ping_restart_disjoint, (ping_all & restart_all) == '0, "channel pinged and restarted together")
	// A pinged channel waits and a restarted one does not.
	`MCHW_ASSERT_IMPLY(a_result_waiting, result_valid_q, ((result_q.ping_mask & ~result_q.waiting_mask) == '0) && ((result_q.restart_mask & result_q.waiting_mask) == '0), "waiting mask disagrees with ping or restart")
	// Channels that are not built never report waiting.
	`MCHW_ASSERT_IMPLY(a_absent_idle, result_valid_q, ((result_q.waiting_mask >> NUM_CHANNELS) == '0), "absent channel reported waiting")

endmodule
